// ----- design/matrix4_multiply_top_macros.svh -----
// Assertion macros shared by the checker of the 4x4 matrix product block.
`ifndef MATRIX4_MULTIPLY_TOP_MACROS_SVH
`define MATRIX4_MULTIPLY_TOP_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define MM4_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define MM4_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/mm4_pkg.sv -----
// Package with the shared types, constants and opcodes of the matrix product block.
`timescale 1ns / 1ps
`default_nettype none

package mm4_pkg;

  // Element and matrix geometry.
  localparam int ELEM_W      = 32;
  localparam int MATRIX_DIM  = 4;
  localparam int DIM_BITS    = $clog2(MATRIX_DIM);
  localparam int ELEM_COUNT  = MATRIX_DIM * MATRIX_DIM;
  localparam int IDX_W       = 2 * DIM_BITS;
  localparam int OP_W        = 2;

  // Product and accumulator widths: four full products need two guard bits.
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int ACC_W       = PROD_W + DIM_BITS;

  // Default number of fraction bits of the fixed-point format.
  localparam int FRAC_BITS_DEF = 16;

  // Opcodes of an input word.
  localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  // Saturation limits of a result element.
  localparam logic [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             issue;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] a_addr;
    logic [IDX_W-1:0] b_addr;
  } mm4_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stall;
  } mm4_sts_t;

endpackage

`default_nettype wire

// ----- design/mm4_if.sv -----
// Handshake interfaces of the input and result channels.
`timescale 1ns / 1ps
`default_nettype none

// Input channel: opcode, element index and element value.
interface mm4_in_if;
  logic                              valid;
  logic                              ready;
  logic [mm4_pkg::OP_W-1:0]          opcode;
  logic [mm4_pkg::IDX_W-1:0]         elem_index;
  logic signed [mm4_pkg::ELEM_W-1:0] elem_value;

  modport source (output valid, output opcode, output elem_index, output elem_value,
                  input ready);
  modport sink   (input valid, input opcode, input elem_index, input elem_value,
                  output ready);
endinterface

// Result channel: one product element per word.
interface mm4_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [mm4_pkg::ELEM_W-1:0] prod_value;
  logic [mm4_pkg::IDX_W-1:0]         prod_index;
  logic                              last_of_run;
  logic                              clipped;

  modport source (output valid, output prod_value, output prod_index,
                  output last_of_run, output clipped, input ready);
  modport sink   (input valid, input prod_value, input prod_index,
                  input last_of_run, input clipped, output ready);
endinterface

`default_nettype wire

// ----- design/mm4_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- design/mm4_ctrl.sv -----
// Controller that takes input words and sequences the reads of a product run.
`timescale 1ns / 1ps
`default_nettype none

module mm4_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [mm4_pkg::OP_W-1:0]   in_opcode,
  output logic                            in_ready,
  output mm4_pkg::mm4_cmd_t               cmd,
  input  wire mm4_pkg::mm4_sts_t          sts
);

  localparam logic [mm4_pkg::DIM_BITS-1:0] K_LAST =
    mm4_pkg::DIM_BITS'(mm4_pkg::MATRIX_DIM - 1);
  localparam logic [mm4_pkg::IDX_W-1:0] E_LAST =
    mm4_pkg::IDX_W'(mm4_pkg::ELEM_COUNT - 1);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t                         state_r;
  logic                           in_ready_r;
  logic [mm4_pkg::IDX_W-1:0]      e_r;
  logic [mm4_pkg::DIM_BITS-1:0]   k_r;
  logic                           accept;
  logic                           step;
  logic [mm4_pkg::DIM_BITS-1:0]   row;
  logic [mm4_pkg::DIM_BITS-1:0]   col;

  assign accept   = in_valid && in_ready_r;
  assign step     = (state_r == ST_RUN) && !sts.stall;
  assign in_ready = in_ready_r;

  // Row and column of the product element being worked on.
  assign row = e_r[mm4_pkg::IDX_W-1:mm4_pkg::DIM_BITS];
  assign col = e_r[mm4_pkg::DIM_BITS-1:0];

  // Commands: loads write the stores, a run reads one pair a cycle unless stalled.
  always_comb begin
    cmd        = '0;
    cmd.wr_a   = accept && (in_opcode == mm4_pkg::OP_LOAD_A);
    cmd.wr_b   = accept && (in_opcode == mm4_pkg::OP_LOAD_B);
    cmd.issue  = step;
    cmd.first  = (k_r == '0);
    cmd.last   = (k_r == K_LAST);
    cmd.idx    = e_r;
    cmd.a_addr = {row, k_r};
    cmd.b_addr = {k_r, col};
  end

  // State, counters and the registered ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
      e_r        <= '0;
      k_r        <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept && (in_opcode == mm4_pkg::OP_COMPUTE)) begin
            state_r    <= ST_RUN;
            in_ready_r <= 1'b0;
            e_r        <= '0;
            k_r        <= '0;
          end
        end
        ST_RUN: begin
          if (step) begin
            k_r <= k_r + 1'b1;
            if (k_r == K_LAST) begin
              e_r <= e_r + 1'b1;
              if (e_r == E_LAST) begin
                state_r    <= ST_IDLE;
                in_ready_r <= 1'b1;
              end
            end
          end
        end
        default: begin
          state_r    <= ST_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/mm4_datapath.sv -----
// Datapath: matrix stores, shared multiply-accumulate, scaling, saturation, result register.
`timescale 1ns / 1ps
`default_nettype none

module mm4_datapath #(
  parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire mm4_pkg::mm4_cmd_t                   cmd,
  output mm4_pkg::mm4_sts_t                        sts,
  input  wire logic [mm4_pkg::IDX_W-1:0]           wr_index,
  input  wire logic [mm4_pkg::ELEM_W-1:0]          wr_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [mm4_pkg::ELEM_W-1:0]        out_value,
  output logic [mm4_pkg::IDX_W-1:0]                out_index,
  output logic                                     out_last,
  output logic                                     out_clip
);

  localparam int ELEM_W = mm4_pkg::ELEM_W;
  localparam int PROD_W = mm4_pkg::PROD_W;
  localparam int ACC_W  = mm4_pkg::ACC_W;
  localparam logic [mm4_pkg::IDX_W-1:0] E_LAST =
    mm4_pkg::IDX_W'(mm4_pkg::ELEM_COUNT - 1);

  logic [ELEM_W-1:0]              a_rd;
  logic [ELEM_W-1:0]              b_rd;
  logic signed [ELEM_W-1:0]       a_s;
  logic signed [ELEM_W-1:0]       b_s;
  logic                           stall;
  logic                           rd_en;

  // Stage one: read data of the stores.
  logic                           v1_r;
  logic                           first1_r;
  logic                           last1_r;
  logic [mm4_pkg::IDX_W-1:0]      idx1_r;

  // Stage two: registered product.
  logic                           v2_r;
  logic                           first2_r;
  logic                           last2_r;
  logic [mm4_pkg::IDX_W-1:0]      idx2_r;
  logic signed [PROD_W-1:0]       prod_r;
  logic signed [PROD_W-1:0]       prod_nxt;

  // Accumulator and final scaling.
  logic signed [ACC_W-1:0]        acc_r;
  logic signed [ACC_W-1:0]        acc_base;
  logic signed [ACC_W-1:0]        acc_sum;
  logic signed [ACC_W-1:0]        shifted;
  logic [ACC_W-ELEM_W:0]          upper;
  logic                           fits;
  logic                           load_out;

  // Result register.
  logic                           out_valid_r;
  logic [ELEM_W-1:0]              out_value_r;
  logic [ELEM_W-1:0]              out_value_nxt;
  logic [mm4_pkg::IDX_W-1:0]      out_index_r;
  logic                           out_last_r;
  logic                           out_clip_r;

  // The pipeline holds when the final sum is ready but the result word is still waiting.
  assign stall     = v2_r && last2_r && out_valid_r && !out_ready;
  assign sts.stall = stall;
  assign rd_en     = cmd.issue;

  // Matrix stores.
  mm4_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (mm4_pkg::ELEM_COUNT)
  ) u_ram_a (
    .clk     (clk),
    .we      (cmd.wr_a),
    .wr_addr (wr_index),
    .wr_data (wr_value),
    .re      (rd_en),
    .rd_addr (cmd.a_addr),
    .rd_data (a_rd)
  );

  mm4_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (mm4_pkg::ELEM_COUNT)
  ) u_ram_b (
    .clk     (clk),
    .we      (cmd.wr_b),
    .wr_addr (wr_index),
    .wr_data (wr_value),
    .re      (rd_en),
    .rd_addr (cmd.b_addr),
    .rd_data (b_rd)
  );

  // Signed 32 by 32 multiply of the pair that the stores read out.
  assign a_s      = $signed(a_rd);
  assign b_s      = $signed(b_rd);
  assign prod_nxt = a_s * b_s;

  // Accumulate, shift right arithmetically, then check the 32-bit range.
  assign acc_base = first2_r ? '0 : acc_r;
  assign acc_sum  = acc_base + ACC_W'(prod_r);
  assign shifted  = acc_sum >>> FRAC_BITS;
  assign upper    = shifted[ACC_W-1:ELEM_W-1];
  assign fits     = (&upper) || !(|upper);
  assign load_out = v2_r && last2_r && !stall;

  always_comb begin
    if (fits) begin
      out_value_nxt = shifted[ELEM_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      out_value_nxt = mm4_pkg::SAT_MIN;
    end else begin
      out_value_nxt = mm4_pkg::SAT_MAX;
    end
  end

  // Pipeline valid bits and the result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!stall) begin
        v1_r <= rd_en;
        v2_r <= v1_r;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (!stall) begin
      if (rd_en) begin
        first1_r <= cmd.first;
        last1_r  <= cmd.last;
        idx1_r   <= cmd.idx;
      end
      first2_r <= first1_r;
      last2_r  <= last1_r;
      idx2_r   <= idx1_r;
      prod_r   <= prod_nxt;
      if (v2_r) begin
        acc_r <= acc_sum;
      end
    end
    if (load_out) begin
      out_value_r <= out_value_nxt;
      out_index_r <= idx2_r;
      out_last_r  <= (idx2_r == E_LAST);
      out_clip_r  <= !fits;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = $signed(out_value_r);
  assign out_index = out_index_r;
  assign out_last  = out_last_r;
  assign out_clip  = out_clip_r;

endmodule

`default_nettype wire

// ----- design/matrix4_multiply_top.sv -----
// Top level of the 4x4 signed fixed-point matrix product block.
//
//   channel | dir | words
//   --------+-----+-------------------------------------------------------
//   in_ch   | in  | opcode, elem_index, elem_value (load A, load B, compute)
//   out_ch  | out | prod_value, prod_index, last_of_run, clipped
//
// A load word gives no result.
// A compute word holds the input until its run has been read out: the shared
// multiply-accumulate sums four products per product element, and the words leave
// in index order, each after its last product is summed, scaled and saturated.
// Reset is synchronous and active low; the matrix stores are not cleared.
// A stalled result word holds the multiply-accumulate pipeline until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module matrix4_multiply_top #(
  parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mm4_in_if.sink     in_ch,
  mm4_out_if.source  out_ch
);

  mm4_pkg::mm4_cmd_t cmd;
  mm4_pkg::mm4_sts_t sts;

  // Controller.
  mm4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath.
  mm4_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .wr_index  (in_ch.elem_index),
    .wr_value  ($unsigned(in_ch.elem_value)),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_value (out_ch.prod_value),
    .out_index (out_ch.prod_index),
    .out_last  (out_ch.last_of_run),
    .out_clip  (out_ch.clipped)
  );

endmodule

`default_nettype wire

// ----- design/mm4_checker.sv -----
// Port checker of the matrix product block and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "matrix4_multiply_top_macros.svh"

module mm4_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic [mm4_pkg::OP_W-1:0]    in_opcode,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [mm4_pkg::ELEM_W-1:0]  out_value,
  input wire logic [mm4_pkg::IDX_W-1:0]   out_index,
  input wire logic                        out_last,
  input wire logic                        out_clip
);

  localparam logic [mm4_pkg::IDX_W-1:0] E_LAST =
    mm4_pkg::IDX_W'(mm4_pkg::ELEM_COUNT - 1);

  // Nothing is offered on the result side right after reset.
  `MM4_ASSERT_ALL(a_out_idle_after_reset, clk, !rst_n |=> !out_valid, "result word after reset")

  // A word that waits keeps its payload.
  `MM4_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_index) && $stable(out_last) && $stable(out_clip), "stalled result word changed")

  // The run flag marks exactly the final element.
  `MM4_ASSERT_RST(a_last_index, clk, rst_n, out_valid |-> (out_last == (out_index == E_LAST)), "last flag and index disagree")

  // A compute word closes the input while its run is read out.
  `MM4_ASSERT_RST(a_compute_blocks, clk, rst_n, in_valid && in_ready && (in_opcode == mm4_pkg::OP_COMPUTE) |=> !in_ready, "input open during a run")

endmodule

bind matrix4_multiply_top mm4_checker u_mm4_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_opcode (in_ch.opcode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.prod_value),
  .out_index (out_ch.prod_index),
  .out_last  (out_ch.last_of_run),
  .out_clip  (out_ch.clipped)
);

`default_nettype wire

// ----- sim/tb_matrix4_multiply_top.sv -----
// Self-checking testbench for the 4x4 fixed-point matrix product block.
`timescale 1ns / 1ps

module tb_matrix4_multiply_top;
  import mm4_pkg::*;

  // Opcode that the block must ignore.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int FRAC = FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WORDS = 170;

  // One product element as the result channel carries it.
  typedef struct {
    logic signed [ELEM_W-1:0] value;
    logic [IDX_W-1:0]         index;
    logic                     last;
    logic                     clipped;
  } product_word_t;

  logic clk = 1'b0;
  logic rst_n;

  mm4_in_if  in_ch ();
  mm4_out_if out_ch ();

  matrix4_multiply_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copies of the two operand matrices.
  logic signed [ELEM_W-1:0] left_elems  [ELEM_COUNT];
  logic signed [ELEM_W-1:0] right_elems [ELEM_COUNT];

  product_word_t pending_products[$];

  int send_gap_max = 3;
  int recv_gap_max = 3;
  int hold_cycles  = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // One element of A times B: exact sum of four products, arithmetic shift,
  // then saturation to 32 bits.
  function automatic product_word_t product_element(input int row, input int col);
    product_word_t            w;
    logic signed [PROD_W-1:0] term;
    logic signed [ACC_W-1:0]  sum;
    logic signed [ACC_W-1:0]  scaled;
    sum = '0;
    for (int k = 0; k < MATRIX_DIM; k++) begin
      term = left_elems[row * MATRIX_DIM + k] * right_elems[k * MATRIX_DIM + col];
      sum = sum + term;
    end
    scaled = sum >>> FRAC;
    w.index = IDX_W'(row * MATRIX_DIM + col);
    w.last  = (row * MATRIX_DIM + col) == ELEM_COUNT - 1;
    if (scaled[ACC_W-1:ELEM_W-1] == '0 ||
        scaled[ACC_W-1:ELEM_W-1] == {(ACC_W-ELEM_W+1){1'b1}}) begin
      w.value   = scaled[ELEM_W-1:0];
      w.clipped = 1'b0;
    end else begin
      w.value   = scaled[ACC_W-1] ? SAT_MIN : SAT_MAX;
      w.clipped = 1'b1;
    end
    return w;
  endfunction

  // Applies one accepted input word to the shadow state.
  task automatic absorb_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic signed [ELEM_W-1:0] val);
    case (op)
      OP_LOAD_A: left_elems[idx] = val;
      OP_LOAD_B: right_elems[idx] = val;
      OP_COMPUTE: begin
        for (int r = 0; r < MATRIX_DIM; r++)
          for (int c = 0; c < MATRIX_DIM; c++)
            pending_products.push_back(product_element(r, c));
      end
      default: ;
    endcase
  endtask

  // Offers one word after a random gap and waits until it is taken.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic signed [ELEM_W-1:0] val);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.elem_index <= idx;
    in_ch.elem_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    absorb_word(op, idx, val);
  endtask

  // Element values: small Q16.16 numbers, some extremes, some raw bits.
  function automatic logic [ELEM_W-1:0] random_element();
    logic [ELEM_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      4, 5: begin
        case ($urandom_range(0, 5))
          0: v = SAT_MAX;
          1: v = SAT_MIN;
          2: v = '0;
          3: v = '1;
          4: v = 32'h0000_0001;
          default: v = 32'h0001_0000;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Result side: random stalls per word, and a long hold when requested.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        stall = $urandom_range(0, recv_gap_max);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
        while (!(out_ch.valid && out_ch.ready) && hold_cycles == 0) @(posedge clk);
      end
    end
  end

  // Compares each accepted product word with the oldest expectation.
  always @(posedge clk) begin
    product_word_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
      if (pending_products.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected product word index %0d value %h", $realtime,
                   out_ch.prod_index, out_ch.prod_value);
      end else begin
        want = pending_products.pop_front();
        if (out_ch.prod_value !== want.value || out_ch.prod_index !== want.index ||
            out_ch.last_of_run !== want.last || out_ch.clipped !== want.clipped) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch idx/val/last/clip exp %0d %h %b %b got %0d %h %b %b",
                     $realtime, want.index, want.value, want.last, want.clipped,
                     out_ch.prod_index, out_ch.prod_value, out_ch.last_of_run,
                     out_ch.clipped);
        end
      end
    end
  end

  // Fills both matrices at every index, then multiplies them.
  task automatic test_preload_and_multiply();
    for (int i = 0; i < ELEM_COUNT; i++)
      send_word(OP_LOAD_A, IDX_W'(i), (i - 7) * 32'sh0000_8000);
    for (int i = 0; i < ELEM_COUNT; i++)
      send_word(OP_LOAD_B, IDX_W'(i), ((i % 5) - 2) * 32'sh0001_0000 + i);
    send_word(OP_COMPUTE, '0, '0);
  endtask

  // Extreme operands that drive elements past both ends of the range.
  task automatic test_saturation();
    send_word(OP_LOAD_A, 4'd0, SAT_MAX);
    send_word(OP_LOAD_B, 4'd0, SAT_MAX);
    send_word(OP_LOAD_A, 4'd4, SAT_MIN);
    send_word(OP_LOAD_A, 4'd15, 32'sh0000_0001);
    send_word(OP_LOAD_B, 4'd15, -32'sd1);
    send_word(OP_LOAD_B, 4'd8, SAT_MIN);
    send_word(OP_COMPUTE, 4'd15, SAT_MIN);
  endtask

  // The unused opcode must change nothing and produce nothing.
  task automatic test_unused_opcode();
    send_word(OP_UNUSED, 4'd15, SAT_MIN);
    send_word(OP_UNUSED, 4'd0, '1);
    send_word(OP_COMPUTE, 4'd0, SAT_MAX);
  endtask

  // Result side held off for a long time while words keep coming.
  task automatic test_backpressure();
    send_gap_max = 0;
    hold_cycles = 400;
    send_word(OP_COMPUTE, '0, '0);
    for (int i = 0; i < 4; i++)
      send_word(OP_LOAD_A, IDX_W'($urandom_range(0, 15)), random_element());
    send_word(OP_COMPUTE, '0, '0);
    send_word(OP_LOAD_B, IDX_W'($urandom_range(0, 15)), random_element());
    send_word(OP_COMPUTE, '0, '0);
  endtask

  // Random mix of loads, products and ignored words in phases with varied gaps.
  task automatic test_random_traffic();
    int pick;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      case (n)
        0:   begin send_gap_max = 10; recv_gap_max = 10; end
        50:  begin send_gap_max = 0;  recv_gap_max = 0;  end
        90:  begin send_gap_max = 0;  recv_gap_max = 10; end
        130: begin send_gap_max = 10; recv_gap_max = 0;  end
        default: ;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 12)
        send_word(OP_COMPUTE, IDX_W'($urandom), $urandom);
      else if (pick < 17)
        send_word(OP_UNUSED, IDX_W'($urandom), $urandom);
      else
        send_word(pick[0] ? OP_LOAD_B : OP_LOAD_A, IDX_W'($urandom_range(0, 15)),
                  random_element());
    end
  endtask

  // Reset, test sequence, drain and verdict.
  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_LOAD_A;
    in_ch.elem_index <= '0;
    in_ch.elem_value <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_preload_and_multiply();
    test_saturation();
    test_unused_opcode();
    test_backpressure();
    test_random_traffic();

    in_ch.valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
